### hw/rtl/oec_pkg.sv
// shared types and constants of the octal escape codec
package oec_pkg;

    // default width of the running field counter
    localparam int COUNT_WIDTH_DEF = 16;

    // width of the length field on the result channel
    localparam int LENGTH_WIDTH = 16;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // character constants
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;
    localparam logic [7:0] DIGIT_ZERO = 8'd48;
    localparam logic [7:0] BACKSLASH  = 8'h5c;

    // decoder escape phase codes
    localparam logic [1:0] PHASE_IDLE     = 2'd0;
    localparam logic [1:0] PHASE_DIGIT_LO = 2'd3;

    // command kinds passed from front to back
    typedef logic [1:0] cmd_kind_t;
    localparam cmd_kind_t CMD_DATA   = 2'd0;
    localparam cmd_kind_t CMD_ERROR  = 2'd1;
    localparam cmd_kind_t CMD_ESCAPE = 2'd2;

    // output steps of one encoded escape
    typedef logic [2:0] step_t;
    localparam step_t STEP_SLASH_A  = 3'd0;
    localparam step_t STEP_SLASH_B  = 3'd1;
    localparam step_t STEP_DIGIT_HI = 3'd2;
    localparam step_t STEP_DIGIT_MD = 3'd3;
    localparam step_t STEP_DIGIT_LO = 3'd4;

    // one command in the queue
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } cmd_t;

endpackage

### hw/rtl/oec_front.sv
// front end: accepts input bytes, tracks decode escapes, issues commands
module oec_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic          cfg_mode,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_in_byte,
    input  logic          s_in_last,
    output logic          push_valid,
    input  logic          push_ready,
    output oec_pkg::cmd_t push_cmd
);
    import oec_pkg::*;

    logic       mode_reg,  mode_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] value_reg, value_next;
    logic       accept;
    logic       produce;
    logic [7:0] digit_sum;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;
    assign push_valid = accept && produce;

    // partial escape value shifted by one octal digit
    assign digit_sum = {value_reg[4:0], 3'b000} + s_in_byte - DIGIT_ZERO;

    // classify the byte and advance the escape state
    always_comb begin
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        value_next    = value_reg;
        produce       = 1'b0;
        push_cmd.kind = CMD_DATA;
        push_cmd.data = s_in_byte;
        push_cmd.last = s_in_last;
        if (mode_reg) begin
            produce = 1'b1;
            if (s_in_byte < PRINT_LOW || s_in_byte > PRINT_HIGH) begin
                push_cmd.kind = CMD_ESCAPE;
            end
        end else if (phase_reg == PHASE_IDLE) begin
            if (s_in_byte == BACKSLASH) begin
                phase_next = phase_reg + 2'd1;
                value_next = 8'd0;
                if (s_in_last) begin
                    produce       = 1'b1;
                    push_cmd.kind = CMD_ERROR;
                    push_cmd.data = 8'd0;
                end
            end else begin
                produce = 1'b1;
            end
        end else begin
            phase_next = phase_reg + 2'd1;
            value_next = digit_sum;
            if (phase_reg == PHASE_DIGIT_LO) begin
                produce       = 1'b1;
                push_cmd.data = digit_sum;
                phase_next    = PHASE_IDLE;
                value_next    = 8'd0;
            end else if (s_in_last) begin
                produce       = 1'b1;
                push_cmd.kind = CMD_ERROR;
                push_cmd.data = 8'd0;
            end
        end
        if (!accept) begin
            phase_next = phase_reg;
            value_next = value_reg;
        end else if (s_in_last) begin
            phase_next = PHASE_IDLE;
            value_next = 8'd0;
        end
        if (cfg_valid) begin
            mode_next  = cfg_mode;
            phase_next = PHASE_IDLE;
            value_next = 8'd0;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            phase_reg <= PHASE_IDLE;
            value_reg <= 8'd0;
        end else begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            value_reg <= value_next;
        end
    end

endmodule

### hw/rtl/oec_queue.sv
// short command queue between front and back
module oec_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  oec_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output oec_pkg::cmd_t pop_cmd
);
    import oec_pkg::*;

    localparam int PtrWidth = $clog2(QUEUE_DEPTH);
    localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] fill_reg,   fill_next;
    logic                do_push, do_pop;

    assign push_ready = (fill_reg != CntWidth'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // command storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/oec_back.sv
// back end: expands commands into results, keeps the field count
module oec_back #(
    parameter int COUNT_WIDTH = oec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_clear,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  oec_pkg::cmd_t                    pop_cmd,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_byte,
    output logic                             m_out_last,
    output logic                             m_out_error,
    output logic [oec_pkg::LENGTH_WIDTH-1:0] m_out_length
);
    import oec_pkg::*;

    logic                    valid_reg,  valid_next;
    step_t                   step_reg,   step_next;
    logic [COUNT_WIDTH-1:0]  count_reg,  count_next;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic [7:0]              byte_reg,   byte_next;
    logic                    last_reg,   last_next;
    logic                    error_reg,  error_next;
    logic [LENGTH_WIDTH-1:0] length_reg, length_next;
    logic                    load;
    logic                    done;
    logic                    is_error;

    assign load      = pop_valid && (!valid_reg || m_ready);
    assign is_error  = (pop_cmd.kind == CMD_ERROR);
    assign done      = (pop_cmd.kind != CMD_ESCAPE) || (step_reg == STEP_DIGIT_LO);
    assign pop_ready = load && done;
    assign count_inc = (count_reg == {COUNT_WIDTH{1'b1}}) ? count_reg
                     : count_reg + 1'b1;

    // build the next result
    always_comb begin
        case (pop_cmd.kind)
            CMD_DATA:   byte_next = pop_cmd.data;
            CMD_ERROR:  byte_next = 8'd0;
            CMD_ESCAPE: begin
                case (step_reg)
                    STEP_SLASH_A, STEP_SLASH_B: byte_next = BACKSLASH;
                    STEP_DIGIT_HI: byte_next = DIGIT_ZERO + {6'd0, pop_cmd.data[7:6]};
                    STEP_DIGIT_MD: byte_next = DIGIT_ZERO + {5'd0, pop_cmd.data[5:3]};
                    default:       byte_next = DIGIT_ZERO + {5'd0, pop_cmd.data[2:0]};
                endcase
            end
            default:    byte_next = 8'd0;
        endcase
        last_next   = pop_cmd.last && done;
        error_next  = is_error;
        length_next = is_error ? LENGTH_WIDTH'(count_reg) : LENGTH_WIDTH'(count_inc);
    end

    // control and count update
    always_comb begin
        valid_next = valid_reg;
        step_next  = step_reg;
        count_next = count_reg;
        if (load) begin
            valid_next = 1'b1;
            step_next  = done ? STEP_SLASH_A : step_reg + 1'b1;
            if (last_next) begin
                count_next = '0;
            end else if (!is_error) begin
                count_next = count_inc;
            end
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
        if (cfg_clear) begin
            step_next  = STEP_SLASH_A;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= STEP_SLASH_A;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= byte_next;
            last_reg   <= last_next;
            error_reg  <= error_next;
            length_reg <= length_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_out_last   = last_reg;
    assign m_out_error  = error_reg;
    assign m_out_length = length_reg;

endmodule

### hw/rtl/octal_escape_codec.sv
// top level of the octal escape byte codec
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_mode) selects decode (0) or
//   encode (1); a write also starts a new field. Write only while idle.
//   s_ channel carries one byte and its field-end flag per transfer;
//   m_ channel returns result bytes with last, error and running length.
// Each result passes through the command queue and then the result register.
// Throughput: one input byte per cycle while the queue has room; an
//   encoded escape holds the back end for its five output characters
//   while the front keeps taking bytes until the four-entry queue fills.
// Decode: a backslash plus three characters yield one byte; a field that
//   ends inside an escape yields a single error result.
// Reset (aresetn low, synchronous): decode mode, no open escape, count
//   zero, queue empty, no result pending.
// Receiver stall: the result register holds; the queue absorbs up to four
//   commands, then s_ready drops until the receiver takes results again.
module octal_escape_codec #(
    parameter int COUNT_WIDTH = oec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_mode,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_in_byte,
    input  logic                             s_in_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_byte,
    output logic                             m_out_last,
    output logic                             m_out_error,
    output logic [oec_pkg::LENGTH_WIDTH-1:0] m_out_length
);
    import oec_pkg::*;

    logic cfg_write;
    logic push_valid, push_ready;
    logic pop_valid,  pop_ready;
    cmd_t push_cmd,   pop_cmd;

    // configuration is always taken
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // classifier
    oec_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_write),
        .cfg_mode   (cfg_mode),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // command queue
    oec_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // result generator
    oec_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_clear    (cfg_write),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_last   (m_out_last),
        .m_out_error  (m_out_error),
        .m_out_length (m_out_length)
    );

endmodule
